### hdl/shabs_pkg.sv
package shabs_pkg;

    // Input queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Block geometry, in bytes
    localparam logic [6:0] BLK_BYTES = 7'd64;
    localparam logic [6:0] LEN_POS   = 7'd56;
    localparam logic [7:0] PAD_BYTE  = 8'h80;

    // One classified input transaction
    typedef struct packed {
        logic       finish;  // 1: pad and emit digest, 0: absorb data
        logic [7:0] data;
    } t_item;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

### hdl/shabs_front.sv
module shabs_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
    input  logic                  s_axis_tuser,   // [0] op
    output logic                  o_item_valid,
    input  logic                  i_item_ready,
    output shabs_pkg::t_item      o_item
);
    import shabs_pkg::*;

    t_item            r_q [QDEPTH];
    logic [QAW-1:0]   r_wr;
    logic [QAW-1:0]   r_rd;
    logic [QAW:0]     r_cnt;
    logic             push;
    logic             pop;
    t_item            in_item;

    // Classify the incoming transaction
    always_comb begin
        in_item.finish = s_axis_tuser;
        in_item.data   = s_axis_tdata;
    end

    assign s_axis_tready = (r_cnt != QDEPTH[QAW:0]);
    assign o_item_valid  = (r_cnt != '0);
    assign o_item        = r_q[r_rd];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = o_item_valid && i_item_ready;

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= in_item;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### hdl/shabs_core.sv
module shabs_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_item_valid,
    output logic                  o_item_ready,
    input  shabs_pkg::t_item      i_item,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [39:0]           m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic                  m_axis_tlast    // last_word
);
    import shabs_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_RND  = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]   r_state, n_state;
    logic [6:0]   r_fill, n_fill;
    logic [63:0]  r_count, n_count;
    logic [5:0]   r_rnd, n_rnd;
    logic [2:0]   r_idx, n_idx;
    logic         r_pad, n_pad;
    logic         r_final, n_final;
    logic [31:0]  r_hash [8];
    logic [31:0]  n_hash [8];
    logic [31:0]  r_v [8];
    logic [31:0]  n_v [8];
    logic [511:0] r_blk, n_blk;

    logic         pop;
    logic         out_take;
    logic [31:0]  w_cur;
    logic [31:0]  w_new;
    logic [31:0]  t1;
    logic [31:0]  t2;
    logic [31:0]  ch;
    logic [31:0]  maj;

    assign o_item_ready  = (r_state == S_IDLE);
    assign pop           = i_item_valid && o_item_ready;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign out_take      = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = {5'b0, r_idx, r_hash[r_idx]};
    assign m_axis_tlast  = (r_idx == 3'd7);

    // Round datapath; the block register doubles as the message schedule window
    assign w_cur = r_blk[511:480];
    assign w_new = w_cur + ssig0(r_blk[479:448]) + r_blk[223:192] + ssig1(r_blk[63:32]);
    assign ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1    = r_v[7] + bsig1(r_v[4]) + ch + K_TAB[r_rnd] + w_cur;
    assign t2    = bsig0(r_v[0]) + maj;

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_count = r_count;
        n_rnd   = r_rnd;
        n_idx   = r_idx;
        n_pad   = r_pad;
        n_final = r_final;
        n_hash  = r_hash;
        n_v     = r_v;
        n_blk   = r_blk;
        unique case (r_state)
            S_IDLE: begin
                if (pop) begin
                    n_fill = r_fill + 7'd1;
                    if (i_item.finish) begin
                        n_blk   = {r_blk[503:0], PAD_BYTE};
                        n_pad   = 1'b1;
                        n_state = S_PAD;
                    end else begin
                        n_blk   = {r_blk[503:0], i_item.data};
                        n_count = r_count + 64'd8;
                    end
                    if (r_fill == BLK_BYTES - 7'd1) begin
                        n_state = S_RND;
                        n_v     = r_hash;
                        n_rnd   = '0;
                    end
                end
            end
            S_PAD: begin
                if (r_fill == LEN_POS) begin
                    // length field closes the final block
                    n_blk   = {r_blk[447:0], r_count};
                    n_final = 1'b1;
                    n_state = S_RND;
                    n_v     = r_hash;
                    n_rnd   = '0;
                end else begin
                    n_blk  = {r_blk[503:0], 8'h00};
                    n_fill = r_fill + 7'd1;
                    if (r_fill == BLK_BYTES - 7'd1) begin
                        n_state = S_RND;
                        n_v     = r_hash;
                        n_rnd   = '0;
                    end
                end
            end
            S_RND: begin
                n_v[7] = r_v[6];
                n_v[6] = r_v[5];
                n_v[5] = r_v[4];
                n_v[4] = r_v[3] + t1;
                n_v[3] = r_v[2];
                n_v[2] = r_v[1];
                n_v[1] = r_v[0];
                n_v[0] = t1 + t2;
                n_blk  = {r_blk[479:0], w_new};
                n_rnd  = r_rnd + 6'd1;
                if (r_rnd == 6'd63) n_state = S_ADD;
            end
            S_ADD: begin
                for (int i = 0; i < 8; i++) n_hash[i] = r_hash[i] + r_v[i];
                n_fill = '0;
                if (r_final) begin
                    n_state = S_OUT;
                    n_idx   = '0;
                end else if (r_pad) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (out_take) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_hash  = H_INIT;
                        n_count = '0;
                        n_fill  = '0;
                        n_pad   = 1'b0;
                        n_final = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control and hash state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_count <= '0;
            r_rnd   <= '0;
            r_idx   <= '0;
            r_pad   <= 1'b0;
            r_final <= 1'b0;
            r_hash  <= H_INIT;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_count <= n_count;
            r_rnd   <= n_rnd;
            r_idx   <= n_idx;
            r_pad   <= n_pad;
            r_final <= n_final;
            r_hash  <= n_hash;
        end
    end

    // Working variables and block window
    always_ff @(posedge i_clk) begin
        r_v   <= n_v;
        r_blk <= n_blk;
    end

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= BLK_BYTES)
        else $error("block fill out of range");

    a_rnd_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RND && r_rnd != 6'd63) |=> (r_state == S_RND && r_rnd == $past(r_rnd) + 6'd1))
        else $error("compression round sequence broken");

    a_absorb_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_item.finish) |=> (r_count == $past(r_count) + 64'd8))
        else $error("bit count not advanced on absorb");

    a_digest_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && r_idx == 3'd7) |=> (r_count == '0 && r_fill == '0 && r_state == S_IDLE))
        else $error("state not cleared after digest");

endmodule

### hdl/sha256_byte_stream_hash.sv
// SHA-256 over a byte stream.
// Input channel (s_axis): one transaction per message byte. tuser = 0 absorbs
// tdata as the next message byte; tuser = 1 closes the message (tdata ignored).
// Output channel (m_axis): after a close, eight transactions carry the digest,
// h0 first; tdata[31:0] is the word, tdata[34:32] its index, tlast marks the
// eighth. The block then starts over with the initial hash value.
// An absorb is taken whenever the core is idle; each time a 64-byte block
// fills, the core runs 64 rounds at one round per cycle and a feed-forward
// add before it takes the next transaction. A close pads byte by byte, runs
// one or two compressions, then hands out the digest words as they are taken.
// The shared round unit runs one round per cycle.
// A four-entry input queue keeps taking transactions while the hash engine
// is busy or the output is stalled; s_axis_tready drops only when it is full.
// While m_axis_tready is low the current digest word holds steady.
// Reset (i_rst_n low, synchronous) empties the queue, drops any partial
// message and loads the initial hash value.
module sha256_byte_stream_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_axis_tlast    // last_word
);
    import shabs_pkg::*;

    logic  item_valid;
    logic  item_ready;
    t_item item;

    shabs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_item_valid  (item_valid),
        .i_item_ready  (item_ready),
        .o_item        (item)
    );

    shabs_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (item_valid),
        .o_item_ready  (item_ready),
        .i_item        (item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### tb/sv/sha256_byte_stream_hash_checker.sv
module sha256_byte_stream_hash_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] op
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    input  logic        m_axis_tlast,   // last_word
    output int          o_fail_count,
    output int          o_pending,
    output int          o_words_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import shabs_pkg::*;

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    // Predicted hash state
    logic [31:0]  chain_h [8];
    logic [7:0]   msg_buf [64];
    logic [6:0]   buf_fill;
    logic [63:0]  bit_len;
    t_digest_word digest_q [$];

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned r);
        return (x >> r) | (x << (32 - r));
    endfunction

    // One 64-round compression of msg_buf into chain_h
    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2, ch, maj;
        for (int t = 0; t < 16; t++) begin
            w[t] = {msg_buf[4*t], msg_buf[4*t+1], msg_buf[4*t+2], msg_buf[4*t+3]};
        end
        for (int t = 16; t < 64; t++) begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        v = chain_h;
        for (int t = 0; t < 64; t++) begin
            s1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
            ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1  = v[7] + s1 + ch + SHA_K[t] + w[t];
            s0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
            maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t2  = s0 + maj;
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) begin
            chain_h[i] = chain_h[i] + v[i];
        end
    endfunction

    function automatic void restart_hash();
        chain_h  = SHA_IV;
        buf_fill = '0;
        bit_len  = '0;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        msg_buf[buf_fill[5:0]] = b;
        buf_fill = buf_fill + 7'd1;
        bit_len  = bit_len + 64'd8;
        if (buf_fill == 7'd64) begin
            compress_block();
            buf_fill = '0;
        end
    endfunction

    // Pad, compress the tail and queue the eight digest words
    function automatic void close_message();
        t_digest_word dw;
        msg_buf[buf_fill[5:0]] = 8'h80;
        buf_fill = buf_fill + 7'd1;
        if (buf_fill > 7'd56) begin
            for (int i = buf_fill; i < 64; i++) msg_buf[i] = 8'h00;
            compress_block();
            buf_fill = '0;
        end
        for (int i = buf_fill; i < 56; i++) msg_buf[i] = 8'h00;
        for (int i = 0; i < 8; i++) msg_buf[56+i] = bit_len[63-8*i -: 8];
        compress_block();
        for (int i = 0; i < 8; i++) begin
            dw.word  = chain_h[i];
            dw.index = 3'(i);
            dw.last  = (i == 7);
            digest_q.push_back(dw);
        end
        restart_hash();
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch: %s: got %h, expected %h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_words_checked = 0;
    end

    // Watch both channels, predict on input, compare on output
    always @(posedge i_clk) begin : watch
        t_item        in_tr;
        t_digest_word want;
        if (!i_rst_n) begin
            restart_hash();
            digest_q.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                in_tr = {s_axis_tuser, s_axis_tdata};
                if (in_tr.finish) close_message();
                else absorb_byte(in_tr.data);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (digest_q.size() == 0) begin
                    report_mismatch("digest transaction with nothing pending",
                                    m_axis_tdata[31:0], 32'h0);
                end else begin
                    want = digest_q.pop_front();
                    o_words_checked++;
                    if (m_axis_tdata[31:0] !== want.word)
                        report_mismatch("digest_word", m_axis_tdata[31:0], want.word);
                    if (m_axis_tdata[34:32] !== want.index)
                        report_mismatch("word_index", 32'(m_axis_tdata[34:32]),
                                        32'(want.index));
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last_word", 32'(m_axis_tlast), 32'(want.last));
                end
            end
        end
        o_pending = digest_q.size();
    end

endmodule

### tb/sv/sha256_byte_stream_hash_tb.sv
module sha256_byte_stream_hash_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic {
        OP_ABSORB = 1'b0,
        OP_FINISH = 1'b1
    } t_op;

    localparam int RANDOM_ITEMS = 300;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 200;
    localparam int IDLE_PCT     = 17;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] data_byte
    logic        s_axis_tuser  = 1'b0;   // [0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;           // [31:0] digest_word, [34:32] word_index
    logic        m_axis_tlast;           // last_word

    int fail_count;
    int pending;
    int words_checked;
    int msg_count  = 0;
    int byte_count = 0;
    bit quiet      = 1'b0;
    bit hold_req   = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    sha256_byte_stream_hash u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    sha256_byte_stream_hash_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_words_checked (words_checked)
    );

    // Offer one transaction, with random idle cycles ahead of it
    task automatic offer_item(input t_op op, input logic [7:0] b);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (op == OP_ABSORB) byte_count++;
        else msg_count++;
    endtask

    // Random message body, then the close (its data byte is don't-care)
    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) offer_item(OP_ABSORB, 8'($urandom));
        offer_item(OP_FINISH, 8'($urandom));
    endtask

    // Stop offering until every digest word has been taken
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Receiver: random backpressure, one long hold-off on request
    initial begin : rx_side
        bit held;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Stimulus and verdict
    initial begin : stim
        int sent;
        int msg_no;
        int len;
        int remaining;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty message
        offer_item(OP_FINISH, 8'h00);
        // "abc"
        offer_item(OP_ABSORB, 8'h61);
        offer_item(OP_ABSORB, 8'h62);
        offer_item(OP_ABSORB, 8'h63);
        offer_item(OP_FINISH, 8'hff);
        // extreme byte values, close carrying a nonzero data byte
        offer_item(OP_ABSORB, 8'h00);
        offer_item(OP_ABSORB, 8'hff);
        offer_item(OP_ABSORB, 8'h80);
        offer_item(OP_ABSORB, 8'h7f);
        offer_item(OP_FINISH, 8'h5a);
        // back-to-back closes
        offer_item(OP_FINISH, 8'ha5);

        // random messages; padding boundaries hit often
        sent   = 0;
        msg_no = 0;
        while (sent < RANDOM_ITEMS) begin
            remaining = RANDOM_ITEMS - sent;
            if (msg_no == 0) begin
                len = 56;
            end else if (msg_no == 1) begin
                len = 64;
            end else if ($urandom_range(99) < 20) begin
                case ($urandom_range(0, 3))
                    0: len = 55;
                    1: len = 57;
                    2: len = 63;
                    default: len = 65;
                endcase
            end else begin
                len = $urandom_range(0, 12);
            end
            if (len >= remaining) len = remaining - 1;
            quiet = (msg_no >= 12 && msg_no < 20);
            if (msg_no == 4) hold_req = 1'b1;
            if (msg_no == 9) drain_results();
            send_message(len);
            sent += len + 1;
            msg_no++;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d messages, %0d message bytes, %0d digest words compared",
                 msg_count, byte_count, words_checked);
        $display("incl. empty message, both padding paths and a %0d-cycle output stall",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("sha256_byte_stream_hash test passed");
        end else begin
            $display("sha256_byte_stream_hash test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #400000;
        $display("sha256_byte_stream_hash test failed");
        $finish;
    end

endmodule

### sha256_byte_stream_hash.f
hdl/shabs_pkg.sv
hdl/shabs_front.sv
hdl/shabs_core.sv
hdl/sha256_byte_stream_hash.sv
tb/sv/sha256_byte_stream_hash_checker.sv
tb/sv/sha256_byte_stream_hash_tb.sv
